// ===== hdl/gkvt_pkg.sv =====
// ----------------------------------------------------------------------------
// gkvt_pkg
// Shared types and constants of the generational key/payload table.
// ----------------------------------------------------------------------------
`default_nettype none

package gkvt_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int HUNKS_CFG_W   = 4;
  localparam int ENTRIES_CFG_W = 7;
  localparam int KEY_W = 64;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_HUNKS_IN_USE     = 2'd0;
  localparam cfg_idx_t REG_ENTRIES_PER_HUNK = 2'd1;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_STORE  = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/generational_key_value_table.sv =====
// ----------------------------------------------------------------------------
// generational_key_value_table
// Key/payload table kept as a ring of equal hunks, searched by a linear scan
// of a key memory, with a payload memory beside it.
//
//   channel  direction  handshake          contents
//   in_      input      in_valid/in_stall  mode, key, payload
//   out_     output     out_valid/out_stall hit, payload
//   cfg_     input      cfg_valid/cfg_ready register index, data
//
// one transaction at a time; it reads the occupied slots one by one from the
// single key memory port, oldest hunk first, until a match or the end; a full
// table with defaults is 512 reads
// a match ends the scan early; a finished result waits in the output register
// reset or a used register write empties the table at once, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module generational_key_value_table #(
  parameter int NUM_HUNKS        = 8,
  parameter int ENTRIES_PER_HUNK = 64,
  parameter int PAYLOAD_WIDTH    = 64
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_mode,
  input  wire  [gkvt_pkg::KEY_W-1:0]       in_key,
  input  wire  [PAYLOAD_WIDTH-1:0]         in_payload_in,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_hit,
  output logic [PAYLOAD_WIDTH-1:0]         out_payload_out,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [gkvt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [gkvt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import gkvt_pkg::*;

  localparam int SLOTS  = NUM_HUNKS * ENTRIES_PER_HUNK;
  localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HIDX_W = (NUM_HUNKS > 1) ? $clog2(NUM_HUNKS) : 1;
  localparam int HCNT_W = $clog2(NUM_HUNKS + 1);
  localparam int ECNT_W = $clog2(ENTRIES_PER_HUNK + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t                state_r, state_nxt;
  logic [HCNT_W-1:0]     nh_r, nh_nxt;
  logic [ECNT_W-1:0]     ne_r, ne_nxt;
  logic [HIDX_W-1:0]     cur_r, cur_nxt;
  logic [HIDX_W-1:0]     old_r, old_nxt;
  logic [HIDX_W-1:0]     lc_r, lc_nxt;
  logic [ECNT_W-1:0]     cur_fill_r, cur_fill_nxt;
  logic [AW-1:0]         cur_base_r, cur_base_nxt;
  logic [AW-1:0]         old_base_r, old_base_nxt;
  logic [HIDX_W-1:0]     scan_l_r, scan_l_nxt;
  logic [HIDX_W-1:0]     scan_p_r, scan_p_nxt;
  logic [ECNT_W-1:0]     scan_i_r, scan_i_nxt;
  logic [AW-1:0]         scan_base_r, scan_base_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [AW-1:0]         rd_addr_r, rd_addr_nxt;
  logic                  res_hit_r, res_hit_nxt;
  logic                  res_mem_r, res_mem_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_hit_r, out_hit_nxt;
  logic [PAYLOAD_WIDTH-1:0] out_pay_r, out_pay_nxt;

  logic                  mode_r;
  logic [KEY_W-1:0]      key_r;
  logic [PAYLOAD_WIDTH-1:0] pin_r;
  logic                  in_take;

  logic [KEY_W-1:0]         key_mem [SLOTS];
  logic [PAYLOAD_WIDTH-1:0] pay_mem [SLOTS];
  logic [KEY_W-1:0]         key_rdata_r;
  logic [PAYLOAD_WIDTH-1:0] pay_rdata_r;

  logic                  key_rd_en, pay_rd_en, key_we, pay_we;
  logic [AW-1:0]         key_rd_addr, wr_addr;

  logic [HUNKS_CFG_W-1:0]   cfg_hunks;
  logic [ENTRIES_CFG_W-1:0] cfg_entries;
  logic [HCNT_W-1:0]        eff_nh;
  logic [ECNT_W-1:0]        eff_ne;

  logic                  key_match;
  logic [ECNT_W-1:0]     scan_limit;
  logic [AW-1:0]         scan_addr;
  logic                  scan_p_wrap;
  logic                  fill_full;
  logic [HIDX_W-1:0]     app_cur, app_old, app_lc;
  logic [AW-1:0]         app_cur_base, app_old_base;
  logic [ECNT_W-1:0]     app_fill;

  assign cfg_ready       = (state_r == S_IDLE);
  assign in_stall        = (state_r != S_IDLE) || cfg_valid;
  assign in_take         = in_valid && !in_stall;
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_payload_out = out_pay_r;

  // clamp register writes to the usable range
  assign cfg_hunks   = cfg_data[HUNKS_CFG_W-1:0];
  assign cfg_entries = cfg_data[ENTRIES_CFG_W-1:0];

  always_comb begin
    if (cfg_hunks == '0) begin
      eff_nh = HCNT_W'(1);
    end else if (int'(cfg_hunks) > NUM_HUNKS) begin
      eff_nh = HCNT_W'(NUM_HUNKS);
    end else begin
      eff_nh = HCNT_W'(cfg_hunks);
    end
    if (cfg_entries == '0) begin
      eff_ne = ECNT_W'(1);
    end else if (int'(cfg_entries) > ENTRIES_PER_HUNK) begin
      eff_ne = ECNT_W'(ENTRIES_PER_HUNK);
    end else begin
      eff_ne = ECNT_W'(cfg_entries);
    end
  end

  assign key_match   = rd_pend_r && (key_rdata_r == key_r);
  assign scan_limit  = (scan_l_r == lc_r) ? cur_fill_r : ne_r;
  assign scan_addr   = scan_base_r + AW'(scan_i_r);
  assign scan_p_wrap = (int'(scan_p_r) + 1 == int'(nh_r));

  // placement of a new key, moving on to the next hunk or recycling the oldest
  always_comb begin
    fill_full    = (cur_fill_r >= ne_r);
    app_cur      = cur_r;
    app_old      = old_r;
    app_lc       = lc_r;
    app_cur_base = cur_base_r;
    app_old_base = old_base_r;
    app_fill     = cur_fill_r;
    if (fill_full) begin
      app_fill = '0;
      if (int'(lc_r) + 1 < int'(nh_r)) begin
        app_lc = lc_r + HIDX_W'(1);
        if (int'(cur_r) + 1 == int'(nh_r)) begin
          app_cur      = '0;
          app_cur_base = '0;
        end else begin
          app_cur      = cur_r + HIDX_W'(1);
          app_cur_base = cur_base_r + AW'(ENTRIES_PER_HUNK);
        end
      end else begin
        app_cur      = old_r;
        app_cur_base = old_base_r;
        if (int'(old_r) + 1 == int'(nh_r)) begin
          app_old      = '0;
          app_old_base = '0;
        end else begin
          app_old      = old_r + HIDX_W'(1);
          app_old_base = old_base_r + AW'(ENTRIES_PER_HUNK);
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    nh_nxt        = nh_r;
    ne_nxt        = ne_r;
    cur_nxt       = cur_r;
    old_nxt       = old_r;
    lc_nxt        = lc_r;
    cur_fill_nxt  = cur_fill_r;
    cur_base_nxt  = cur_base_r;
    old_base_nxt  = old_base_r;
    scan_l_nxt    = scan_l_r;
    scan_p_nxt    = scan_p_r;
    scan_i_nxt    = scan_i_r;
    scan_base_nxt = scan_base_r;
    rd_pend_nxt   = 1'b0;
    rd_addr_nxt   = rd_addr_r;
    res_hit_nxt   = res_hit_r;
    res_mem_nxt   = res_mem_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_hit_nxt   = out_hit_r;
    out_pay_nxt   = out_pay_r;
    key_rd_en     = 1'b0;
    key_rd_addr   = scan_addr;
    pay_rd_en     = 1'b0;
    key_we        = 1'b0;
    pay_we        = 1'b0;
    wr_addr       = rd_addr_r;

    case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          if (cfg_index == REG_HUNKS_IN_USE || cfg_index == REG_ENTRIES_PER_HUNK) begin
            if (cfg_index == REG_HUNKS_IN_USE) begin
              nh_nxt = eff_nh;
            end else begin
              ne_nxt = eff_ne;
            end
            cur_nxt      = '0;
            old_nxt      = '0;
            lc_nxt       = '0;
            cur_fill_nxt = '0;
            cur_base_nxt = '0;
            old_base_nxt = '0;
          end
        end else if (in_take) begin
          scan_l_nxt    = '0;
          scan_p_nxt    = old_r;
          scan_i_nxt    = '0;
          scan_base_nxt = old_base_r;
          state_nxt     = S_SCAN;
        end
      end

      S_SCAN: begin
        if (key_match) begin
          res_hit_nxt = 1'b1;
          if (mode_r == MODE_LOOKUP) begin
            pay_rd_en   = 1'b1;
            res_mem_nxt = 1'b1;
          end else begin
            pay_we      = 1'b1;
            res_mem_nxt = 1'b0;
          end
          state_nxt = S_FINISH;
        end else if (scan_i_r != scan_limit) begin
          key_rd_en   = 1'b1;
          rd_addr_nxt = scan_addr;
          rd_pend_nxt = 1'b1;
          scan_i_nxt  = scan_i_r + ECNT_W'(1);
        end else if (scan_l_r != lc_r) begin
          scan_l_nxt = scan_l_r + HIDX_W'(1);
          scan_i_nxt = '0;
          if (scan_p_wrap) begin
            scan_p_nxt    = '0;
            scan_base_nxt = '0;
          end else begin
            scan_p_nxt    = scan_p_r + HIDX_W'(1);
            scan_base_nxt = scan_base_r + AW'(ENTRIES_PER_HUNK);
          end
        end else begin
          res_hit_nxt = 1'b0;
          res_mem_nxt = 1'b0;
          if (mode_r == MODE_STORE) begin
            key_we       = 1'b1;
            pay_we       = 1'b1;
            wr_addr      = app_cur_base + AW'(app_fill);
            cur_nxt      = app_cur;
            old_nxt      = app_old;
            lc_nxt       = app_lc;
            cur_base_nxt = app_cur_base;
            old_base_nxt = app_old_base;
            cur_fill_nxt = app_fill + ECNT_W'(1);
          end
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_pay_nxt   = res_mem_r ? pay_rdata_r : '0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nh_r        <= HCNT_W'(NUM_HUNKS);
      ne_r        <= ECNT_W'(ENTRIES_PER_HUNK);
      cur_r       <= '0;
      old_r       <= '0;
      lc_r        <= '0;
      cur_fill_r  <= '0;
      cur_base_r  <= '0;
      old_base_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nh_r        <= nh_nxt;
      ne_r        <= ne_nxt;
      cur_r       <= cur_nxt;
      old_r       <= old_nxt;
      lc_r        <= lc_nxt;
      cur_fill_r  <= cur_fill_nxt;
      cur_base_r  <= cur_base_nxt;
      old_base_r  <= old_base_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    scan_l_r    <= scan_l_nxt;
    scan_p_r    <= scan_p_nxt;
    scan_i_r    <= scan_i_nxt;
    scan_base_r <= scan_base_nxt;
    rd_addr_r   <= rd_addr_nxt;
    res_hit_r   <= res_hit_nxt;
    res_mem_r   <= res_mem_nxt;
    out_hit_r   <= out_hit_nxt;
    out_pay_r   <= out_pay_nxt;
    if (in_take) begin
      mode_r <= in_mode;
      key_r  <= in_key;
      pin_r  <= in_payload_in;
    end
  end

  // key and payload memories
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_r;
    end
    if (key_rd_en) begin
      key_rdata_r <= key_mem[key_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[wr_addr] <= pin_r;
    end
    if (pay_rd_en) begin
      pay_rdata_r <= pay_mem[rd_addr_r];
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the generational key/payload table. A shadow of the
// table (hunk ring, fill counts, retirement) computes hit and payload for
// every accepted transaction. Results are compared in order, field by field.
// The run covers several register settings, out-of-range values and unused
// register indexes, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import gkvt_pkg::*;

  localparam int HUNKS       = 8;
  localparam int DEPTH       = 64;
  localparam int CYCLE_LIMIT = 3000000;
  localparam cfg_idx_t REG_SPARE_A = 2'd2;
  localparam cfg_idx_t REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [63:0] key;
    logic [63:0] payload;
    logic        drain;
  } kv_op_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] payload;
  } kv_answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = MODE_LOOKUP;
  logic [63:0] in_key = '0;
  logic [63:0] in_payload_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_hit;
  logic [63:0] out_payload_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = REG_HUNKS_IN_USE;
  logic [6:0]  cfg_data = '0;

  kv_op_t      pending_ops [$];
  kv_answer_t  due_answers [$];
  logic [63:0] key_pool [$];
  kv_op_t      shown_op;
  int          pool_cap = 96;
  int          ops_queued = 0;
  int          ops_taken = 0;
  int          faults = 0;
  int          cycle_cnt = 0;
  bit          quiet = 1'b0;

  // shadow of the table
  logic [63:0] key_mem [HUNKS*DEPTH];
  logic [63:0] pay_mem [HUNKS*DEPTH];
  int unsigned hunk_fill [HUNKS];
  int unsigned cur_h;
  int unsigned old_h;
  logic [3:0]  hunks_reg;
  logic [6:0]  entries_reg;

  generational_key_value_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_key          (in_key),
    .in_payload_in   (in_payload_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_payload_out (out_payload_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned live_hunks();
    if (hunks_reg == 0) return 1;
    if (hunks_reg > HUNKS) return HUNKS;
    return 32'(hunks_reg);
  endfunction

  function automatic int unsigned live_entries();
    if (entries_reg == 0) return 1;
    if (entries_reg > DEPTH) return DEPTH;
    return 32'(entries_reg);
  endfunction

  function automatic void empty_table();
    for (int h = 0; h < HUNKS; h++) hunk_fill[h] = 0;
    cur_h = 0;
    old_h = 0;
  endfunction

  function automatic void write_reg_shadow(cfg_idx_t idx, logic [6:0] val);
    case (idx)
      REG_HUNKS_IN_USE: begin
        hunks_reg = val[3:0];
        empty_table();
      end
      REG_ENTRIES_PER_HUNK: begin
        entries_reg = val;
        empty_table();
      end
      default: begin
      end
    endcase
  endfunction

  function automatic int find_key(logic [63:0] k);
    for (int h = 0; h < live_hunks(); h++)
      for (int i = 0; i < hunk_fill[h]; i++)
        if (key_mem[h*DEPTH+i] == k) return h*DEPTH + i;
    return -1;
  endfunction

  function automatic kv_answer_t apply_op(kv_op_t op);
    kv_answer_t  ans;
    int          slot;
    int unsigned nh;
    int unsigned ne;
    int unsigned pos;
    slot = find_key(op.key);
    nh = live_hunks();
    ne = live_entries();
    ans.hit = (slot >= 0);
    ans.payload = '0;
    if (op.mode == MODE_LOOKUP) begin
      if (slot >= 0) ans.payload = pay_mem[slot];
      return ans;
    end
    if (slot >= 0) begin
      pay_mem[slot] = op.payload;
      return ans;
    end
    if (cur_h >= nh) cur_h = 0;
    if (old_h >= nh) old_h = 0;
    if (hunk_fill[cur_h] >= ne) begin
      if ((cur_h + nh - old_h) % nh + 1 < nh) begin
        cur_h = (cur_h + 1) % nh;
      end else begin
        // oldest generation is dropped and reused as the newest
        cur_h = old_h;
        hunk_fill[cur_h] = 0;
        old_h = (old_h + 1) % nh;
      end
    end
    if (hunk_fill[cur_h] < DEPTH) begin
      pos = cur_h*DEPTH + hunk_fill[cur_h];
      key_mem[pos] = op.key;
      pay_mem[pos] = op.payload;
      hunk_fill[cur_h]++;
    end
    return ans;
  endfunction

  // input channel
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      due_answers.insert(due_answers.size(), apply_op(shown_op));
      ops_taken++;
    end
    if (!in_valid || !in_stall) begin
      if (rst_n && pending_ops.size() > 0 &&
          !(pending_ops[0].drain && (due_answers.size() > 0 || out_valid)) &&
          (quiet || $urandom_range(99) >= 10)) begin
        shown_op = pending_ops[0];
        pending_ops.delete(0);
        in_valid <= 1'b1;
        in_mode <= shown_op.mode;
        in_key <= shown_op.key;
        in_payload_in <= shown_op.payload;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result channel
  always @(posedge clk) begin : result_check
    kv_answer_t want;
    out_stall <= rst_n && !quiet && ($urandom_range(99) < 10);
    if (out_valid && !out_stall) begin
      if (due_answers.size() == 0) begin
        $error("unexpected result transaction: hit %0b payload_out %h",
               out_hit, out_payload_out);
        faults++;
      end else begin
        want = due_answers[0];
        due_answers.delete(0);
        if (out_hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, out_hit);
          faults++;
        end
        if (out_payload_out !== want.payload) begin
          $error("payload_out: expected %h, got %h", want.payload, out_payload_out);
          faults++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("generational_key_value_table verification failed");
      $finish;
    end
  end

  task automatic add_op(input logic mode, input logic [63:0] key,
                        input logic [63:0] payload, input logic drain);
    kv_op_t op;
    op.mode = mode;
    op.key = key;
    op.payload = payload;
    op.drain = drain;
    pending_ops.insert(pending_ops.size(), op);
    ops_queued++;
  endtask

  task automatic random_ops(input int n);
    logic [63:0] k;
    logic [63:0] p;
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 70 && key_pool.size() > 0) begin
        k = key_pool[$urandom_range(key_pool.size() - 1)];
      end else if (r < 80) begin
        case ($urandom_range(3))
          0: k = '0;
          1: k = '1;
          2: k = 64'd1 << $urandom_range(63);
          default: k = ~(64'd1 << $urandom_range(63));
        endcase
      end else begin
        k = {$urandom, $urandom};
        if (key_pool.size() < pool_cap) key_pool.insert(key_pool.size(), k);
        else key_pool[$urandom_range(key_pool.size() - 1)] = k;
      end
      r = $urandom_range(9);
      p = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
      add_op($urandom_range(1) ? MODE_STORE : MODE_LOOKUP, k, p,
             $urandom_range(49) == 0);
    end
  endtask

  task automatic wait_idle();
    while (ops_taken != ops_queued || due_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [6:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    write_reg_shadow(idx, val);
  endtask

  task automatic set_shape(input logic [6:0] hunks, input logic [6:0] entries);
    wait_idle();
    write_reg(REG_HUNKS_IN_USE, hunks);
    write_reg(REG_ENTRIES_PER_HUNK, entries);
    key_pool.delete();
    pool_cap = live_hunks() * live_entries();
    pool_cap = pool_cap + pool_cap / 2 + 2;
    if (pool_cap > 96) pool_cap = 96;
  endtask

  initial begin
    hunks_reg = HUNKS;
    entries_reg = DEPTH;
    empty_table();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, corner keys, overwrite, one-bit key difference
    add_op(MODE_LOOKUP, '0, '1, 1'b0);
    add_op(MODE_STORE, '0, '1, 1'b0);
    add_op(MODE_STORE, '1, '0, 1'b0);
    add_op(MODE_LOOKUP, '0, '0, 1'b0);
    add_op(MODE_LOOKUP, '1, '1, 1'b0);
    add_op(MODE_STORE, '0, 64'h5555_5555_5555_5555, 1'b0);
    add_op(MODE_LOOKUP, '0, '0, 1'b1);
    add_op(MODE_LOOKUP, 64'h8000_0000_0000_0000, '0, 1'b0);
    add_op(MODE_STORE, 64'h8000_0000_0000_0000, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    add_op(MODE_LOOKUP, 64'h8000_0000_0000_0000, '1, 1'b0);
    random_ops(120);

    set_shape(7'd1, 7'd1);
    random_ops(100);

    // zero counts act as one: second store retires the first key
    set_shape(7'd0, 7'd0);
    add_op(MODE_STORE, 64'h0123_4567_89ab_cdef, 64'h1111_2222_3333_4444, 1'b0);
    add_op(MODE_STORE, 64'hfedc_ba98_7654_3210, 64'h5555_6666_7777_8888, 1'b0);
    add_op(MODE_LOOKUP, 64'h0123_4567_89ab_cdef, '0, 1'b0);
    add_op(MODE_LOOKUP, 64'hfedc_ba98_7654_3210, '0, 1'b0);
    add_op(MODE_STORE, 64'hfedc_ba98_7654_3210, 64'h9999_aaaa_bbbb_cccc, 1'b0);
    random_ops(80);

    set_shape(7'd9, 7'd2);
    random_ops(120);
    set_shape(7'h73, 7'd5);
    random_ops(120);

    // unused indexes leave the table as it is
    wait_idle();
    write_reg(REG_SPARE_A, 7'h7f);
    write_reg(REG_SPARE_B, 7'h00);
    random_ops(80);

    quiet = 1'b1;
    set_shape(7'd8, 7'd4);
    random_ops(130);
    wait_idle();
    quiet = 1'b0;

    set_shape(7'd5, 7'd7);
    random_ops(110);
    set_shape(7'd2, 7'h7f);
    random_ops(120);
    set_shape(7'd1, 7'd64);
    random_ops(80);
    set_shape(7'd15, 7'd3);
    random_ops(90);

    wait_idle();
    repeat (16) @(posedge clk);
    if (faults == 0 && due_answers.size() == 0) begin
      $display("generational_key_value_table verification clean");
    end else begin
      $display("generational_key_value_table verification failed");
    end
    $finish;
  end

endmodule
